/* rtl/rrtt_pkg.sv */
`timescale 1ns / 1ps

package rrtt_pkg;

   localparam int SLOTS    = 16;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W     = 4;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      SLOT_FREE     = 2'd0,
      SLOT_RUNNING  = 2'd1,
      SLOT_RUNNABLE = 2'd2,
      SLOT_EXITED   = 2'd3
   } slot_state_type;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_YIELD  = 2'd1,
      OP_EXIT   = 2'd2,
      OP_JOIN   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK       = 3'd0,
      RSP_FULL     = 3'd1,
      RSP_NOSUCH   = 3'd2,
      RSP_NOTCHILD = 3'd3,
      RSP_WAITING  = 3'd4,
      RSP_HALT     = 3'd5
   } rsp_status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } rrtt_cmd_type;

   // sum is below twice SLOTS: one compare and subtract
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] sum);
      logic [SLOT_W:0] res;
      res = sum;
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
         res = sum - (SLOT_W+1)'(SLOTS);
      end
      return res[SLOT_W-1:0];
   endfunction

endpackage

/* rtl/rrtt_if.sv */
`timescale 1ns / 1ps

interface rrtt_req_if;
   logic                         valid;
   logic                         ready;
   logic [rrtt_pkg::OP_W-1:0]    operation;
   logic [rrtt_pkg::ID_W-1:0]    target_id;

   modport source (output valid, output operation, output target_id, input ready);
   modport sink   (input valid, input operation, input target_id, output ready);
endinterface

interface rrtt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rrtt_pkg::STATUS_W-1:0] status;
   logic [rrtt_pkg::ID_W-1:0]     created_id;
   logic [rrtt_pkg::ID_W-1:0]     running_id;
   logic                          switched;

   modport source (output valid, output status, output created_id, output running_id,
                   output switched, input ready);
   modport sink   (input valid, input status, input created_id, input running_id,
                   input switched, output ready);
endinterface

/* rtl/rrtt_ctrl.sv */
`timescale 1ns / 1ps

module rrtt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rrtt_pkg::rrtt_cmd_type cmd
);
   import rrtt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready = !out_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = CTRL_IDLE;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.execute) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_fire_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == CTRL_EXEC)
      else $error("request accepted without execute cycle");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_EXEC |-> !out_valid_ff)
      else $error("execute with response register occupied");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_EXEC |=> out_valid_ff)
      else $error("execute did not load a response");

   a_exec_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_EXEC |-> !req_ready)
      else $error("request accepted during execute");

endmodule

/* rtl/rrtt_datapath.sv */
`timescale 1ns / 1ps

module rrtt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rrtt_pkg::rrtt_cmd_type        cmd,
   input  logic [rrtt_pkg::OP_W-1:0]     req_operation,
   input  logic [rrtt_pkg::ID_W-1:0]     req_target_id,
   output logic [rrtt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrtt_pkg::ID_W-1:0]     rsp_created_id,
   output logic [rrtt_pkg::ID_W-1:0]     rsp_running_id,
   output logic                          rsp_switched
);
   import rrtt_pkg::*;

   slot_state_type    slot_ff   [SLOTS];
   slot_state_type    slot_in   [SLOTS];
   logic [SLOT_W-1:0] parent_ff [SLOTS];
   logic [SLOT_W-1:0] parent_in [SLOTS];
   logic [SLOT_W-1:0] cur_ff, cur_in;

   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   tgt_ff;

   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     created_ff;
   logic [ID_W-1:0]     running_ff;
   logic                switched_ff;

   logic [SLOTS-1:0]  runnable;
   logic [SLOTS-2:0]  rot;
   logic              rr_found;
   logic [SLOT_W-1:0] rr_idx;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic              alive_other;
   slot_state_type    cur_state;
   logic              tgt_ok;
   logic [SLOT_W-1:0] tgt_idx;
   rsp_status_type    status;
   logic [SLOT_W-1:0] created;

   // hold the request
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= OP_CREATE;
         tgt_ff <= '0;
      end else if (cmd.capture) begin
         op_ff  <= req_operation;
         tgt_ff <= req_target_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i]   <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
            parent_ff[i] <= '0;
         end
         cur_ff <= '0;
      end else if (cmd.execute) begin
         slot_ff   <= slot_in;
         parent_ff <= parent_in;
         cur_ff    <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff   <= status;
         created_ff  <= ID_W'(created);
         running_ff  <= ID_W'(cur_in);
         switched_ff <= (cur_in != cur_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         runnable[i] = (slot_ff[i] == SLOT_RUNNABLE);
      end
      for (int i = 0; i < SLOTS - 1; i++) begin
         rot[i] = runnable[wrap_slot((SLOT_W+1)'(cur_ff) + (SLOT_W+1)'(i + 1))];
      end
   end

   // first runnable slot after the current one
   always_comb begin
      rr_found = 1'b0;
      rr_idx   = '0;
      for (int i = SLOTS - 2; i >= 0; i--) begin
         if (rot[i]) begin
            rr_found = 1'b1;
            rr_idx   = wrap_slot((SLOT_W+1)'(cur_ff) + (SLOT_W+1)'(i + 1));
         end
      end
   end

   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      alive_other = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_ff[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (SLOT_W'(i) != cur_ff &&
             (slot_ff[i] == SLOT_RUNNING || slot_ff[i] == SLOT_RUNNABLE)) begin
            alive_other = 1'b1;
         end
      end
   end

   assign cur_state = slot_ff[cur_ff];
   assign tgt_ok    = (32'(tgt_ff) < 32'(SLOTS));
   assign tgt_idx   = SLOT_W'(tgt_ff);

   always_comb begin
      slot_in   = slot_ff;
      parent_in = parent_ff;
      cur_in    = cur_ff;
      status    = RSP_OK;
      created   = '0;
      unique case (op_type'(op_ff))
         OP_CREATE: begin
            if (free_found) begin
               parent_in[free_idx] = cur_ff;
               slot_in[free_idx]   = SLOT_RUNNABLE;
               created             = free_idx;
            end else begin
               status = RSP_FULL;
            end
         end
         OP_YIELD: begin
            if (rr_found) begin
               if (cur_state == SLOT_RUNNING) begin
                  slot_in[cur_ff] = SLOT_RUNNABLE;
               end
               slot_in[rr_idx] = SLOT_RUNNING;
               cur_in          = rr_idx;
            end else if (cur_state == SLOT_RUNNING || cur_state == SLOT_RUNNABLE) begin
               slot_in[cur_ff] = SLOT_RUNNING;
            end else begin
               status = RSP_HALT;
            end
         end
         OP_EXIT: begin
            slot_in[cur_ff] = SLOT_EXITED;
            if (alive_other && rr_found) begin
               slot_in[rr_idx] = SLOT_RUNNING;
               cur_in          = rr_idx;
            end else begin
               status = RSP_HALT;
            end
         end
         OP_JOIN: begin
            if (!tgt_ok || slot_ff[tgt_idx] == SLOT_FREE) begin
               status = RSP_NOSUCH;
            end else if (parent_ff[tgt_idx] != cur_ff) begin
               status = RSP_NOTCHILD;
            end else if (slot_ff[tgt_idx] == SLOT_EXITED) begin
               slot_in[tgt_idx] = SLOT_FREE;
            end else if (rr_found) begin
               if (cur_state == SLOT_RUNNING) begin
                  slot_in[cur_ff] = SLOT_RUNNABLE;
               end
               slot_in[rr_idx] = SLOT_RUNNING;
               cur_in          = rr_idx;
               status          = RSP_WAITING;
            end else if (cur_state == SLOT_RUNNING || cur_state == SLOT_RUNNABLE) begin
               slot_in[cur_ff] = SLOT_RUNNING;
               status          = RSP_WAITING;
            end else begin
               status = RSP_HALT;
            end
         end
      endcase
   end

   assign rsp_status     = status_ff;
   assign rsp_created_id = created_ff;
   assign rsp_running_id = running_ff;
   assign rsp_switched   = switched_ff;

endmodule

/* rtl/round_robin_thread_table_top.sv */
`timescale 1ns / 1ps

// Round-robin thread table: slot states, parent ids and the running thread id.
// Channels: req carries operation (create, yield, exit, join) and target_id;
// rsp returns status, created_id, running_id and switched, one per request.
// A request and a response move when valid and ready are both high.
// Timing: an accepted request is executed in the following cycle, which loads its
// response into the output register. The execute cycle does the lowest-free and
// round-robin runnable searches over all slots in one step; req.ready is low
// during it, so no new request is accepted until it is done.
// Reset (synchronous, active high): slot 0 running and current, all other
// slots free, all parent ids zero, no response pending.
// Stall: a waiting response is held in the output register; the next request
// is still accepted in the cycle the response is taken, otherwise req.ready
// stays low until rsp.ready drains the register.
module round_robin_thread_table_top (
   input logic      clock,
   input logic      reset,
   rrtt_req_if.sink   req,
   rrtt_rsp_if.source rsp
);
   import rrtt_pkg::*;

   rrtt_cmd_type cmd;

   rrtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   rrtt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req.operation),
      .req_target_id  (req.target_id),
      .rsp_status     (rsp.status),
      .rsp_created_id (rsp.created_id),
      .rsp_running_id (rsp.running_id),
      .rsp_switched   (rsp.switched)
   );

endmodule

/* bench/tb_round_robin_thread_table_top.sv */
`timescale 1ns / 1ps

module tb_round_robin_thread_table_top;
   import rrtt_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     created_id;
      logic [ID_W-1:0]     running_id;
      logic                switched;
   } sched_reply_type;

   logic clock;
   logic reset;

   rrtt_req_if req_ch ();
   rrtt_rsp_if rsp_ch ();

   round_robin_thread_table_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   slot_state_type shadow_state [SLOTS];
   int             shadow_parent[SLOTS];
   int             shadow_current;

   sched_reply_type sched_replies_q[$];
   sched_reply_type awaited;
   int              error_count;
   int              idle_cycles;
   int              rsp_hold_left;
   int              rsp_stall_left;
   bit              rsp_stall_en;
   bit              req_gap_en;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic bit advance_schedule();
      int cur;
      int idx;
      cur = shadow_current;
      for (int i = 1; i < SLOTS; i++) begin
         idx = (cur + i) % SLOTS;
         if (shadow_state[idx] == SLOT_RUNNABLE) begin
            if (shadow_state[cur] == SLOT_RUNNING) shadow_state[cur] = SLOT_RUNNABLE;
            shadow_state[idx] = SLOT_RUNNING;
            shadow_current = idx;
            return 1'b1;
         end
      end
      if (shadow_state[cur] == SLOT_RUNNING || shadow_state[cur] == SLOT_RUNNABLE) begin
         shadow_state[cur] = SLOT_RUNNING;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic sched_reply_type model_thread_op(op_type op, logic [ID_W-1:0] tgt);
      sched_reply_type r;
      int prior;
      int slot;
      bit alive;
      prior = shadow_current;
      r.status = RSP_OK;
      r.created_id = '0;
      slot = SLOTS;
      alive = 1'b0;
      case (op)
         OP_CREATE: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (shadow_state[i] == SLOT_FREE) slot = i;
            if (slot == SLOTS) begin
               r.status = RSP_FULL;
            end else begin
               shadow_parent[slot] = shadow_current;
               shadow_state[slot] = SLOT_RUNNABLE;
               r.created_id = ID_W'(slot);
            end
         end
         OP_YIELD: begin
            if (!advance_schedule()) r.status = RSP_HALT;
         end
         OP_EXIT: begin
            shadow_state[shadow_current] = SLOT_EXITED;
            for (int i = 0; i < SLOTS; i++)
               if (i != shadow_current && (shadow_state[i] == SLOT_RUNNABLE ||
                                           shadow_state[i] == SLOT_RUNNING))
                  alive = 1'b1;
            if (!alive) r.status = RSP_HALT;
            else if (!advance_schedule()) r.status = RSP_HALT;
         end
         default: begin
            if (int'(tgt) >= SLOTS || shadow_state[tgt] == SLOT_FREE) begin
               r.status = RSP_NOSUCH;
            end else if (shadow_parent[tgt] != shadow_current) begin
               r.status = RSP_NOTCHILD;
            end else if (shadow_state[tgt] == SLOT_EXITED) begin
               shadow_state[tgt] = SLOT_FREE;
            end else begin
               r.status = advance_schedule() ? RSP_WAITING : RSP_HALT;
            end
         end
      endcase
      r.running_id = ID_W'(shadow_current);
      r.switched = (shadow_current != prior);
      return r;
   endfunction

   function automatic logic [ID_W-1:0] pick_target();
      int children[$];
      if ($urandom_range(0, 99) < 65) begin
         for (int i = 0; i < SLOTS && i < 16; i++)
            if (shadow_state[i] != SLOT_FREE && shadow_parent[i] == shadow_current)
               children.push_back(i);
         if (children.size() != 0)
            return ID_W'(children[$urandom_range(0, children.size() - 1)]);
      end
      return ID_W'($urandom_range(0, 15));
   endfunction

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_ch.valid     <= 1'b0;
         req_ch.operation <= op_type'($urandom_range(0, 3));
         req_ch.target_id <= ID_W'($urandom_range(0, 15));
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_request(op_type op, logic [ID_W-1:0] tgt);
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.target_id <= tgt;
      do @(posedge clock); while (!req_ch.ready);
      sched_replies_q.push_back(model_thread_op(op, tgt));
      idle_sender(req_gap_en ? pick_gap() : 0);
   endtask

   task automatic drain_replies();
      idle_sender(1);
      while (sched_replies_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_scheduling();
      req_gap_en = 1'b1;
      rsp_stall_en = 1'b1;
      send_request(OP_YIELD, 4'd9);
      send_request(OP_JOIN, 4'd15);
      send_request(OP_JOIN, 4'd0);
      send_request(OP_CREATE, 4'd6);
      send_request(OP_YIELD, 4'd0);
      send_request(OP_CREATE, 4'd15);
      send_request(OP_JOIN, 4'd1);
      send_request(OP_EXIT, 4'd3);
      send_request(OP_EXIT, 4'd12);
      send_request(OP_JOIN, 4'd1);
      send_request(OP_JOIN, 4'd2);
      send_request(OP_EXIT, 4'd0);
      send_request(OP_YIELD, 4'd5);
      send_request(OP_CREATE, 4'd10);
      send_request(OP_YIELD, 4'd0);
      send_request(OP_JOIN, 4'd2);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_CREATE, ID_W'($urandom_range(0, 15)));
   endtask

   task automatic test_backpressure();
      req_gap_en = 1'b0;
      rsp_hold_left = 120;
      repeat (12) send_request(op_type'($urandom_range(0, 3)), pick_target());
   endtask

   task automatic test_sender_pause();
      req_gap_en = 1'b0;
      rsp_stall_en = 1'b1;
      repeat (6) send_request(op_type'($urandom_range(0, 3)), pick_target());
      drain_replies();
      repeat (6) send_request(op_type'($urandom_range(0, 3)), pick_target());
   endtask

   task automatic test_random_traffic(int count, int w_create, int w_yield, int w_exit,
                                      int w_join, bit gaps);
      int r;
      op_type op;
      req_gap_en = gaps;
      rsp_stall_en = gaps;
      repeat (count) begin
         r = $urandom_range(0, w_create + w_yield + w_exit + w_join - 1);
         if (r < w_create) op = OP_CREATE;
         else if (r < w_create + w_yield) op = OP_YIELD;
         else if (r < w_create + w_yield + w_exit) op = OP_EXIT;
         else op = OP_JOIN;
         send_request(op, (op == OP_JOIN) ? pick_target() : ID_W'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_stall_left = rsp_stall_en ? pick_gap() : 0;
            if (rsp_stall_left > 0) begin
               rsp_ch.ready <= 1'b0;
               rsp_stall_left--;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sched_replies_q.size() == 0) begin
            $display("%0t: unexpected reply status %0d created %0d running %0d switched %0d",
                     $time, rsp_ch.status, rsp_ch.created_id, rsp_ch.running_id,
                     rsp_ch.switched);
            error_count++;
         end else begin
            awaited = sched_replies_q.pop_front();
            if (rsp_ch.status !== awaited.status) begin
               $display("%0t: status expected %0d actual %0d", $time, awaited.status,
                        rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.created_id !== awaited.created_id) begin
               $display("%0t: created_id expected %0d actual %0d", $time,
                        awaited.created_id, rsp_ch.created_id);
               error_count++;
            end
            if (rsp_ch.running_id !== awaited.running_id) begin
               $display("%0t: running_id expected %0d actual %0d", $time,
                        awaited.running_id, rsp_ch.running_id);
               error_count++;
            end
            if (rsp_ch.switched !== awaited.switched) begin
               $display("%0t: switched expected %0d actual %0d", $time, awaited.switched,
                        rsp_ch.switched);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_CREATE;
      req_ch.target_id = '0;
      error_count = 0;
      idle_cycles = 0;
      rsp_hold_left = 0;
      rsp_stall_left = 0;
      rsp_stall_en = 1'b0;
      req_gap_en = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_state[i] = SLOT_FREE;
         shadow_parent[i] = 0;
      end
      shadow_state[0] = SLOT_RUNNING;
      shadow_current = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_scheduling();
      test_table_full();
      test_backpressure();
      test_sender_pause();
      test_random_traffic(220, 30, 30, 15, 25, 1'b1);
      test_random_traffic(140, 15, 25, 35, 25, 1'b1);
      test_random_traffic(140, 45, 25, 10, 20, 1'b0);
      test_random_traffic(200, 25, 25, 20, 30, 1'b1);

      drain_replies();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
